// ===== rtl/homogeneous_vertex_transform_macros.svh =====
`ifndef HOMOGENEOUS_VERTEX_TRANSFORM_MACROS_SVH
`define HOMOGENEOUS_VERTEX_TRANSFORM_MACROS_SVH

// Checked at every rising edge outside reset.
`define HVT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define HVT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/hvt_pkg.sv =====
`default_nettype none

package hvt_pkg;

  localparam int ELEM_BITS = 32;
  localparam int FRAC_BITS = 16;
  localparam int VEC_LEN   = 4;
  localparam int MAT_SIZE  = VEC_LEN * VEC_LEN;
  localparam int IDX_BITS  = $clog2(MAT_SIZE);

  localparam int PROD_W = 2 * ELEM_BITS;
  localparam int PAIR_W = PROD_W + 1;
  localparam int SUM_W  = PROD_W + 2;
  localparam int SHR_W  = SUM_W - FRAC_BITS;

  localparam int IN_FIELDS_W  = IDX_BITS + (VEC_LEN + 1) * ELEM_BITS;
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W  = ((VEC_LEN * ELEM_BITS + 7) / 8) * 8;

  typedef logic signed [ELEM_BITS-1:0] elem_t;
  typedef elem_t [VEC_LEN-1:0]         vec_t;
  typedef logic signed [PROD_W-1:0]    prod_t;
  typedef logic signed [PAIR_W-1:0]    pair_t;
  typedef logic signed [SUM_W-1:0]     sum_t;

  localparam elem_t ELEM_MAX = elem_t'({1'b0, {(ELEM_BITS-1){1'b1}}});
  localparam elem_t ELEM_MIN = elem_t'({1'b1, {(ELEM_BITS-1){1'b0}}});

  typedef enum logic {
    ACT_WRITE = 1'b0,
    ACT_XFORM = 1'b1
  } action_t;

  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } stage_en_t;

endpackage

`default_nettype wire

// ===== rtl/hvt_lane.sv =====
`default_nettype none

module hvt_lane
  import hvt_pkg::*;
(
  input  logic      clk,
  input  stage_en_t en,
  input  vec_t      row,
  input  vec_t      vec,
  output elem_t     res,
  output logic      clip
);

  prod_t prod_r   [VEC_LEN];
  prod_t prod_nxt [VEC_LEN];
  pair_t pair_r   [2];
  pair_t pair_nxt [2];
  sum_t  sum_r;
  sum_t  sum_nxt;
  logic [SHR_W-1:0] shr;
  logic  fits;

  always_comb begin
    for (int c = 0; c < VEC_LEN; c++) begin
      prod_nxt[c] = row[c] * vec[c];
    end
    pair_nxt[0] = pair_t'(prod_r[0]) + pair_t'(prod_r[1]);
    pair_nxt[1] = pair_t'(prod_r[2]) + pair_t'(prod_r[3]);
    sum_nxt     = sum_t'(pair_r[0]) + sum_t'(pair_r[1]);
  end

  always_ff @(posedge clk) begin
    if (en.s1) begin
      prod_r <= prod_nxt;
    end
    if (en.s2) begin
      pair_r <= pair_nxt;
    end
    if (en.s3) begin
      sum_r <= sum_nxt;
    end
  end

  // The sum is floored by the fraction shift, then clipped to the element range.
  always_comb begin
    shr  = sum_r[SUM_W-1:FRAC_BITS];
    fits = (&shr[SHR_W-1:ELEM_BITS-1]) || !(|shr[SHR_W-1:ELEM_BITS-1]);
    clip = !fits;
    if (fits) begin
      res = elem_t'(shr[ELEM_BITS-1:0]);
    end else if (shr[SHR_W-1]) begin
      res = ELEM_MIN;
    end else begin
      res = ELEM_MAX;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/hvt_merge.sv =====
`default_nettype none

module hvt_merge
  import hvt_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   res_valid,
  input  vec_t                   res,
  input  logic [VEC_LEN-1:0]     clip,
  input  logic                   out_tready,
  output logic                   en_out,
  output logic                   out_tvalid,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tuser
);

  logic                   valid_r;
  logic                   valid_nxt;
  logic [OUT_TDATA_W-1:0] data_r;
  logic                   sat_r;

  assign en_out    = !valid_r || out_tready;
  assign valid_nxt = en_out ? res_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en_out && res_valid) begin
      data_r <= OUT_TDATA_W'(res);
      sat_r  <= |clip;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;
  assign out_tuser  = sat_r;

endmodule

`default_nettype wire

// ===== rtl/homogeneous_vertex_transform.sv =====
// A vector word accepted at the input passes the product, pair-sum, sum and output registers before it is offered.
// Throughput: one word per cycle, writes and vectors alike; a stalled output fills
// the four-stage pipeline before in_tready falls.
// Reset: synchronous, active low; clears the matrix to zero and empties the pipeline.
`default_nettype none

module homogeneous_vertex_transform
  import hvt_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // elem_index, elem_value, vec_x, vec_y, vec_z, vec_w, zero fill
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // action
  input  logic                   in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // out_x, out_y, out_z, out_w
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // saturated
  output logic                   out_tuser
);

  elem_t                matrix_r [MAT_SIZE];
  logic [IDX_BITS-1:0]  elem_index;
  elem_t                elem_value;
  vec_t                 vec;
  logic                 in_acc;
  logic                 acc_write;
  logic                 acc_xform;
  stage_en_t            en;
  logic                 en_out;
  logic                 v1_r;
  logic                 v2_r;
  logic                 v3_r;
  vec_t                 res;
  logic [VEC_LEN-1:0]   clip;

  assign elem_index = in_tdata[IDX_BITS-1:0];
  assign elem_value = elem_t'(in_tdata[IDX_BITS +: ELEM_BITS]);

  always_comb begin
    for (int c = 0; c < VEC_LEN; c++) begin
      vec[c] = elem_t'(in_tdata[IDX_BITS + (c + 1) * ELEM_BITS +: ELEM_BITS]);
    end
  end

  assign in_acc    = in_tvalid && in_tready;
  assign acc_write = in_acc && (action_t'(in_tuser) == ACT_WRITE);
  assign acc_xform = in_acc && (action_t'(in_tuser) == ACT_XFORM);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      matrix_r <= '{default: '0};
    end else if (acc_write) begin
      matrix_r[elem_index] <= elem_value;
    end
  end

  always_comb begin
    en.s3 = !v3_r || en_out;
    en.s2 = !v2_r || en.s3;
    en.s1 = !v1_r || en.s2;
  end

  assign in_tready = en.s1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (en.s1) begin
        v1_r <= acc_xform;
      end
      if (en.s2) begin
        v2_r <= v1_r;
      end
      if (en.s3) begin
        v3_r <= v2_r;
      end
    end
  end

  for (genvar r = 0; r < VEC_LEN; r++) begin : g_lane
    vec_t row;

    always_comb begin
      for (int c = 0; c < VEC_LEN; c++) begin
        row[c] = matrix_r[c * VEC_LEN + r];
      end
    end

    hvt_lane u_lane (
      .clk  (clk),
      .en   (en),
      .row  (row),
      .vec  (vec),
      .res  (res[r]),
      .clip (clip[r])
    );
  end

  hvt_merge u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_valid  (v3_r),
    .res        (res),
    .clip       (clip),
    .out_tready (out_tready),
    .en_out     (en_out),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

`default_nettype wire

// ===== rtl/hvt_checker.sv =====
`default_nettype none
`include "homogeneous_vertex_transform_macros.svh"

module hvt_checker
  import hvt_pkg::*;
(
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   in_tvalid,
  input wire logic                   in_tready,
  input wire logic [IN_TDATA_W-1:0]  in_tdata,
  input wire logic                   in_tuser,
  input wire logic                   out_tvalid,
  input wire logic                   out_tready,
  input wire logic [OUT_TDATA_W-1:0] out_tdata,
  input wire logic                   out_tuser
);

  logic acc_xform;

  assign acc_xform = in_tvalid && in_tready && (action_t'(in_tuser) == ACT_XFORM);

  `HVT_ASSERT_ALWAYS(a_reset_empties, !rst_n |=> !out_tvalid, "output valid right after reset")
  `HVT_ASSERT(a_stall_holds, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser), "stalled output word changed")
  `HVT_ASSERT(a_ready_when_flowing, (out_tready || !out_tvalid) |-> in_tready, "input stalled while the output drains")
  `HVT_ASSERT(a_vector_latency, acc_xform ##1 out_tready ##1 out_tready ##1 out_tready |=> out_tvalid, "vector result missing after four free cycles")

endmodule

bind homogeneous_vertex_transform hvt_checker u_hvt_checker (.*);

`default_nettype wire
